/* hdl/chpe_pkg.sv */
// -----------------------------------------------------------------------------
// Complex Horner evaluator package
// Shared widths, request and result types for the polynomial evaluator.
// -----------------------------------------------------------------------------
`default_nettype none
package chpe_pkg;
  localparam int unsigned MaxDegree = 15;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned DataW     = 32;
  localparam int unsigned IdxW      = 4;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_e;

  typedef struct packed {
    logic                     action;
    logic [IdxW-1:0]          coef_index;
    logic signed [DataW-1:0]  coef_re;
    logic signed [DataW-1:0]  coef_im;
    logic signed [DataW-1:0]  z_re;
    logic signed [DataW-1:0]  z_im;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0]  value_re;
    logic signed [DataW-1:0]  value_im;
    logic                     overflow;
  } res_t;
endpackage
`default_nettype wire

/* hdl/chpe_req_if.sv */
// -----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one evaluator request.
// -----------------------------------------------------------------------------
`default_nettype none
interface chpe_req_if;
  logic            valid;
  logic            ready;
  chpe_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/chpe_res_if.sv */
// -----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one evaluator result.
// -----------------------------------------------------------------------------
`default_nettype none
interface chpe_res_if;
  logic            valid;
  logic            ready;
  chpe_pkg::res_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/chpe_step.sv */
// -----------------------------------------------------------------------------
// Horner step
// One complex Horner step in three register stages: products, sums, saturate.
// -----------------------------------------------------------------------------
`default_nettype none
module chpe_step #(
  parameter int unsigned FracBits = chpe_pkg::FracBits,
  parameter int unsigned CountW   = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            valid_i,
  input  wire logic                            active_i,
  input  wire logic [CountW-1:0]               cnt_i,
  input  wire logic signed [chpe_pkg::DataW-1:0] p_re_i,
  input  wire logic signed [chpe_pkg::DataW-1:0] p_im_i,
  input  wire logic signed [chpe_pkg::DataW-1:0] z_re_i,
  input  wire logic signed [chpe_pkg::DataW-1:0] z_im_i,
  input  wire logic signed [chpe_pkg::DataW-1:0] c_re_i,
  input  wire logic signed [chpe_pkg::DataW-1:0] c_im_i,
  input  wire logic                            ovf_i,
  output logic                                 valid_o,
  output logic [CountW-1:0]                    cnt_o,
  output logic signed [chpe_pkg::DataW-1:0]    p_re_o,
  output logic signed [chpe_pkg::DataW-1:0]    p_im_o,
  output logic signed [chpe_pkg::DataW-1:0]    z_re_o,
  output logic signed [chpe_pkg::DataW-1:0]    z_im_o,
  output logic                                 ovf_o
);
  import chpe_pkg::*;
  localparam int unsigned PW = 2 * DataW;
  localparam int unsigned SW = PW - FracBits + 2;

  logic [2:0] v_q;
  logic [1:0] act_q;
  logic [CountW-1:0] cnt1_q, cnt2_q;
  logic signed [DataW-1:0] pr1_q, pi1_q, pr2_q, pi2_q;
  logic signed [DataW-1:0] zr1_q, zi1_q, zr2_q, zi2_q;
  logic signed [DataW-1:0] cr1_q, ci1_q;
  logic o1_q, o2_q;
  logic signed [PW-1:0] ac_q, bd_q, ad_q, bc_q;
  logic signed [SW-1:0] re_d, im_d, re_q, im_q;
  logic signed [SW-1:0] max_s, min_s;
  logic sat_re, sat_im;

  assign max_s = SW'((64'sd1 <<< (DataW - 1)) - 64'sd1);
  assign min_s = -max_s - SW'(1);
  assign re_d = SW'(ac_q >>> FracBits) - SW'(bd_q >>> FracBits) + SW'(cr1_q);
  assign im_d = SW'(ad_q >>> FracBits) + SW'(bc_q >>> FracBits) + SW'(ci1_q);
  assign sat_re = (re_q > max_s) || (re_q < min_s);
  assign sat_im = (im_q > max_s) || (im_q < min_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_q[0] <= active_i;
      cnt1_q <= cnt_i;
      pr1_q <= p_re_i; pi1_q <= p_im_i;
      zr1_q <= z_re_i; zi1_q <= z_im_i;
      cr1_q <= c_re_i; ci1_q <= c_im_i;
      o1_q  <= ovf_i;
      ac_q <= PW'(p_re_i) * PW'(z_re_i);
      bd_q <= PW'(p_im_i) * PW'(z_im_i);
      ad_q <= PW'(p_re_i) * PW'(z_im_i);
      bc_q <= PW'(p_im_i) * PW'(z_re_i);
      act_q[1] <= act_q[0];
      cnt2_q <= cnt1_q;
      pr2_q <= pr1_q; pi2_q <= pi1_q;
      zr2_q <= zr1_q; zi2_q <= zi1_q;
      o2_q  <= o1_q;
      re_q <= re_d;
      im_q <= im_d;
      cnt_o  <= cnt2_q;
      z_re_o <= zr2_q;
      z_im_o <= zi2_q;
      if (act_q[1]) begin
        p_re_o <= sat_re ? (re_q[SW-1] ? min_s[DataW-1:0] : max_s[DataW-1:0])
                         : re_q[DataW-1:0];
        p_im_o <= sat_im ? (im_q[SW-1] ? min_s[DataW-1:0] : max_s[DataW-1:0])
                         : im_q[DataW-1:0];
        ovf_o  <= o2_q | sat_re | sat_im;
      end else begin
        p_re_o <= pr2_q;
        p_im_o <= pi2_q;
        ovf_o  <= o2_q;
      end
    end
  end

  assign valid_o = v_q[2];
endmodule
`default_nettype wire

/* hdl/complex_horner_poly_eval_top.sv */
// -----------------------------------------------------------------------------
// Complex Horner polynomial evaluator
// Pipelined fixed-point evaluation of a complex polynomial at a point.
// -----------------------------------------------------------------------------
// A request on req either writes one coefficient (no result) or evaluates the
// polynomial at z (one result on res). cfg_we_i with cfg_wdata_i sets the
// degree. The Horner chain is unrolled into MaxDegree step units of three
// stages each, and one request is taken every cycle unless the pipeline holds.
// Steps beyond the degree pass the value through. Coefficients are sampled on
// entry, so a write affects only later requests. Reset clears the coefficients,
// the degree and all valid bits. When the receiver stalls, the whole pipeline
// holds only if the last step has a result; while a result waits, the result
// register still lets requests enter as long as the last step is empty.
// -----------------------------------------------------------------------------
`default_nettype none
module complex_horner_poly_eval_top #(
  parameter int unsigned MaxDegree = chpe_pkg::MaxDegree,
  parameter int unsigned FracBits  = chpe_pkg::FracBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  chpe_req_if.sink         req,
  chpe_res_if.source       res
);
  import chpe_pkg::*;
  localparam int unsigned CW = $clog2(MaxDegree + 1);

  logic [3:0] deg_q;
  logic [CW-1:0] ndeg;
  logic signed [DataW-1:0] cre_q [MaxDegree+1];
  logic signed [DataW-1:0] cim_q [MaxDegree+1];
  logic en, acc;

  logic [MaxDegree:0] v;
  logic [CW-1:0] cnt [MaxDegree+1];
  logic signed [DataW-1:0] pr [MaxDegree+1], pi [MaxDegree+1];
  logic signed [DataW-1:0] zr [MaxDegree+1], zi [MaxDegree+1];
  logic [MaxDegree:0] ov;
  logic signed [DataW-1:0] scr [MaxDegree], sci [MaxDegree];

  logic  res_v_q;
  res_t  res_q;

  assign ndeg = ({28'd0, deg_q} > 32'(MaxDegree)) ? CW'(MaxDegree) : CW'(deg_q);
  assign en = !res_v_q || res.ready || !v[MaxDegree];
  assign req.ready = en;
  assign acc = req.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= '0;
      for (int k = 0; k <= MaxDegree; k++) begin
        cre_q[k] <= '0;
        cim_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        deg_q <= cfg_wdata_i;
      end
      if (acc && req.payload.action == ACT_WRITE &&
          {28'd0, req.payload.coef_index} <= 32'(MaxDegree)) begin
        cre_q[CW'(req.payload.coef_index)] <= req.payload.coef_re;
        cim_q[CW'(req.payload.coef_index)] <= req.payload.coef_im;
      end
    end
  end

  // Stage 0 snapshots the coefficient set with the request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= acc && req.payload.action == ACT_EVAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt[0] <= ndeg;
      pr[0]  <= cre_q[ndeg];
      pi[0]  <= cim_q[ndeg];
      zr[0]  <= req.payload.z_re;
      zi[0]  <= req.payload.z_im;
      ov[0]  <= 1'b0;
    end
  end

  // Coefficient snapshots, delayed to line up with each step.
  logic signed [DataW-1:0] snr [MaxDegree+1][MaxDegree+1];
  logic signed [DataW-1:0] sni [MaxDegree+1][MaxDegree+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= MaxDegree; k++) begin
        snr[0][k] <= cre_q[k];
        sni[0][k] <= cim_q[k];
      end
    end
  end

  for (genvar s = 0; s < MaxDegree; s++) begin : g_step
    logic signed [DataW-1:0] dr [3][MaxDegree+1];
    logic signed [DataW-1:0] di [3][MaxDegree+1];
    logic [CW-1:0] kidx;
    logic active;

    assign active = cnt[s] != '0;
    assign kidx = active ? cnt[s] - CW'(1) : '0;
    assign scr[s] = snr[s][kidx];
    assign sci[s] = sni[s][kidx];

    always_ff @(posedge clk_i) begin
      if (en) begin
        dr[0] <= snr[s];
        di[0] <= sni[s];
        dr[1] <= dr[0];
        di[1] <= di[0];
        dr[2] <= dr[1];
        di[2] <= di[1];
      end
    end
    assign snr[s+1] = dr[2];
    assign sni[s+1] = di[2];

    chpe_step #(.FracBits(FracBits), .CountW(CW)) u_step (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v[s]), .active_i(active),
      .cnt_i(active ? cnt[s] - CW'(1) : cnt[s]),
      .p_re_i(pr[s]), .p_im_i(pi[s]), .z_re_i(zr[s]), .z_im_i(zi[s]),
      .c_re_i(scr[s]), .c_im_i(sci[s]), .ovf_i(ov[s]),
      .valid_o(v[s+1]), .cnt_o(cnt[s+1]),
      .p_re_o(pr[s+1]), .p_im_o(pi[s+1]), .z_re_o(zr[s+1]), .z_im_o(zi[s+1]),
      .ovf_o(ov[s+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (!res_v_q || res.ready) begin
      res_v_q <= v[MaxDegree];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v[MaxDegree]) begin
      res_q.value_re <= pr[MaxDegree];
      res_q.value_im <= pi[MaxDegree];
      res_q.overflow <= ov[MaxDegree];
    end
  end

  assign res.valid   = res_v_q;
  assign res.payload = res_q;

  ast_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res.ready |=> res.valid && $stable(res.payload))
    else $error("result changed while stalled");
  ast_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v[MaxDegree] && !en |=> v[MaxDegree])
    else $error("pipeline lost a request during a stall");
  ast_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_v_q |-> req.ready)
    else $error("input blocked with empty result register");
endmodule
`default_nettype wire
